@@ src/rcotc_pkg.sv @@
// package for the rc oscillator trim calibrator: widths, codes and shared types
`timescale 1ns / 1ps
`default_nettype none

package rcotc_pkg;

    // trim widths inside the block
    localparam int COARSE_W = 16;
    localparam int FINE_W   = 8;

    // field and register widths
    localparam int CMD_W      = 2;
    localparam int CRS_FLD_W  = 16;
    localparam int FINE_FLD_W = 8;
    localparam int COUNT_W    = 16;
    localparam int ACT_W      = 3;
    localparam int TRIM_W     = 32;
    localparam int SCALED_W   = 24;
    localparam int SCALE_W    = 8;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    // commands
    localparam logic [CMD_W-1:0] CMD_START = 2'd0;
    localparam logic [CMD_W-1:0] CMD_MEAS  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_ABORT = 2'd2;

    // result actions
    localparam logic [ACT_W-1:0] ACT_STARTED = 3'd0;
    localparam logic [ACT_W-1:0] ACT_APPLY   = 3'd1;
    localparam logic [ACT_W-1:0] ACT_WRITE   = 3'd2;
    localparam logic [ACT_W-1:0] ACT_KEEP    = 3'd3;
    localparam logic [ACT_W-1:0] ACT_ABORTED = 3'd4;
    localparam logic [ACT_W-1:0] ACT_IGNORED = 3'd5;

    // direction of the last fine step
    localparam logic [1:0] DIR_NONE = 2'd0;
    localparam logic [1:0] DIR_LOW  = 2'd1;
    localparam logic [1:0] DIR_HIGH = 2'd2;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_TARGET    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BAND      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_FINE_LOW  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_FINE_HIGH = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_RECENTER  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_CRS_STEP  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_SCALE     = 3'd6;

    // register reset values
    localparam logic [COUNT_W-1:0]    RST_TARGET    = 16'd1638;
    localparam logic [COUNT_W-1:0]    RST_BAND      = 16'd50;
    localparam logic [FINE_FLD_W-1:0] RST_FINE_LOW  = 8'd4;
    localparam logic [FINE_FLD_W-1:0] RST_FINE_HIGH = 8'd60;
    localparam logic [FINE_FLD_W-1:0] RST_RECENTER  = 8'h20;
    localparam logic [CRS_FLD_W-1:0]  RST_CRS_STEP  = 16'd4;
    localparam logic [SCALE_W-1:0]    RST_SCALE     = 8'd20;

    typedef struct packed {
        logic [COUNT_W-1:0]    target;
        logic [COUNT_W-1:0]    band;
        logic [FINE_FLD_W-1:0] fine_low;
        logic [FINE_FLD_W-1:0] fine_high;
        logic [FINE_FLD_W-1:0] recenter;
        logic [CRS_FLD_W-1:0]  crs_step;
        logic [SCALE_W-1:0]    scale;
    } t_cfg;

    typedef struct packed {
        logic [CMD_W-1:0]      cmd;
        logic [CRS_FLD_W-1:0]  start_coarse;
        logic [FINE_FLD_W-1:0] start_fine;
        logic                  record_valid;
        logic [COUNT_W-1:0]    measured_count;
    } t_item;

    typedef struct packed {
        logic                run_active;
        logic [COARSE_W-1:0] coarse;
        logic [FINE_W-1:0]   fine;
        logic [1:0]          dir;
        logic                changed;
        logic                record_ok;
    } t_state;

    typedef struct packed {
        logic [ACT_W-1:0]    action;
        logic [TRIM_W-1:0]   trim_word;
        logic [SCALED_W-1:0] scaled_freq;
    } t_result;

endpackage

`default_nettype wire

@@ src/rc_oscillator_trim_calibrator.sv @@
// top level of the rc oscillator trim calibrator: registers, handshake and step logic
`timescale 1ns / 1ps
`default_nettype none

// Takes one command per clock unless o_stall is high: start, measurement or abort.
// Each transfer gives exactly one result, via the input register and then the
// result register; the calibration state is updated by the combinational step
// logic between them, so back-to-back items see the state left by the one before.
// Sustained rate is one item per cycle while the result side takes transfers;
// o_stall rises only when both registers are full and i_stall is high. The user must
// write registers via i_cfg_we/i_cfg_idx/i_cfg_data only while idle (unchecked).
module rc_oscillator_trim_calibrator (
    input  wire                                   i_clk,
    input  wire                                   i_rst_n,
    input  wire                                   i_cfg_we,
    input  wire [rcotc_pkg::CFG_IDX_W-1:0]        i_cfg_idx,
    input  wire [rcotc_pkg::CFG_DATA_W-1:0]       i_cfg_data,
    input  wire                                   i_valid,
    output logic                                  o_stall,
    input  wire [rcotc_pkg::CMD_W-1:0]            i_cmd,
    input  wire [rcotc_pkg::CRS_FLD_W-1:0]        i_start_coarse,
    input  wire [rcotc_pkg::FINE_FLD_W-1:0]       i_start_fine,
    input  wire                                   i_record_valid,
    input  wire [rcotc_pkg::COUNT_W-1:0]          i_measured_count,
    output logic                                  o_valid,
    input  wire                                   i_stall,
    output logic [rcotc_pkg::ACT_W-1:0]           o_action,
    output logic [rcotc_pkg::TRIM_W-1:0]          o_trim_word,
    output logic [rcotc_pkg::SCALED_W-1:0]        o_scaled_freq
);
    import rcotc_pkg::*;

    t_cfg    r_cfg;
    t_item   r_in;
    logic    r_in_vld;
    t_state  r_state;
    t_state  n_state;
    t_result r_out;
    t_result n_out;
    logic    r_out_vld;
    logic    out_free;
    logic    advance;

    assign out_free = !r_out_vld || !i_stall;
    assign advance  = r_in_vld && out_free;
    assign o_stall  = r_in_vld && !out_free;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.target    <= RST_TARGET;
            r_cfg.band      <= RST_BAND;
            r_cfg.fine_low  <= RST_FINE_LOW;
            r_cfg.fine_high <= RST_FINE_HIGH;
            r_cfg.recenter  <= RST_RECENTER;
            r_cfg.crs_step  <= RST_CRS_STEP;
            r_cfg.scale     <= RST_SCALE;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_TARGET:    r_cfg.target    <= i_cfg_data;
                REG_BAND:      r_cfg.band      <= i_cfg_data;
                REG_FINE_LOW:  r_cfg.fine_low  <= i_cfg_data[FINE_FLD_W-1:0];
                REG_FINE_HIGH: r_cfg.fine_high <= i_cfg_data[FINE_FLD_W-1:0];
                REG_RECENTER:  r_cfg.recenter  <= i_cfg_data[FINE_FLD_W-1:0];
                REG_CRS_STEP:  r_cfg.crs_step  <= i_cfg_data;
                REG_SCALE:     r_cfg.scale     <= i_cfg_data[SCALE_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (!o_stall) begin
            r_in_vld <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && !o_stall) begin
            r_in.cmd            <= i_cmd;
            r_in.start_coarse   <= i_start_coarse;
            r_in.start_fine     <= i_start_fine;
            r_in.record_valid   <= i_record_valid;
            r_in.measured_count <= i_measured_count;
        end
    end

    rcotc_step u_step (
        .i_cfg    (r_cfg),
        .i_state  (r_state),
        .i_item   (r_in),
        .o_state  (n_state),
        .o_result (n_out)
    );

    // calibration state moves together with the result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state.run_active <= 1'b0;
            r_state.coarse     <= '0;
            r_state.fine       <= '0;
            r_state.dir        <= DIR_NONE;
            r_state.changed    <= 1'b0;
            r_state.record_ok  <= 1'b0;
        end else if (advance) begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (out_free) begin
            r_out_vld <= r_in_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out <= n_out;
        end
    end

    assign o_valid       = r_out_vld;
    assign o_action      = r_out.action;
    assign o_trim_word   = r_out.trim_word;
    assign o_scaled_freq = r_out.scaled_freq;

    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_vld && (r_out.action == ACT_WRITE || r_out.action == ACT_KEEP
            || r_out.action == ACT_ABORTED) |-> !r_state.run_active)
        else $error("run still active after a finishing result");

    a_start_active: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_vld && r_out.action == ACT_STARTED |-> r_state.run_active)
        else $error("run not active after start");

    a_apply_changed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_vld && r_out.action == ACT_APPLY |-> r_state.changed && r_state.run_active)
        else $error("trim applied without changed flag");

    a_scaled_only_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_vld && r_out.action != ACT_WRITE |-> r_out.scaled_freq == '0)
        else $error("scaled frequency on a result that writes no record");

    a_stall_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> r_in_vld && r_out_vld && i_stall)
        else $error("input stalled with room in the pipeline");

endmodule

`default_nettype wire

@@ src/rcotc_step.sv @@
// one calibration step: next trim state and result for one input item
`timescale 1ns / 1ps
`default_nettype none

module rcotc_step (
    input  var rcotc_pkg::t_cfg    i_cfg,
    input  var rcotc_pkg::t_state  i_state,
    input  var rcotc_pkg::t_item   i_item,
    output rcotc_pkg::t_state      o_state,
    output rcotc_pkg::t_result     o_result
);
    import rcotc_pkg::*;

    logic [COUNT_W-1:0]  count;
    logic                below;
    logic [COUNT_W:0]    sum_lo;
    logic [COUNT_W:0]    sum_hi;
    logic                finish_lo;
    logic                finish_hi;
    logic                finish;
    logic [FINE_W-1:0]   fine_dn;
    logic [FINE_W-1:0]   fine_up;
    logic [FINE_W-1:0]   recenter;
    logic [COARSE_W-1:0] crs_step;
    logic [SCALED_W-1:0] product;
    t_state              nxt;
    logic [ACT_W-1:0]    action;
    logic [SCALED_W-1:0] scaled;

    assign count    = i_item.measured_count;
    assign below    = count < i_cfg.target;
    // band edges without wrap
    assign sum_lo   = {1'b0, count} + {1'b0, i_cfg.band};
    assign sum_hi   = {1'b0, i_cfg.target} + {1'b0, i_cfg.band};
    assign finish_lo = (i_state.dir == DIR_NONE && sum_lo > {1'b0, i_cfg.target})
                    || i_state.dir == DIR_HIGH;
    assign finish_hi = (i_state.dir == DIR_NONE && {1'b0, count} < sum_hi)
                    || i_state.dir == DIR_LOW;
    assign finish   = below ? finish_lo : finish_hi;
    assign fine_dn  = i_state.fine - FINE_W'(1);
    assign fine_up  = i_state.fine + FINE_W'(1);
    assign recenter = i_cfg.recenter[FINE_W-1:0];
    assign crs_step = i_cfg.crs_step[COARSE_W-1:0];
    // 16 x 8 bits never exceeds the 24-bit product width
    assign product  = SCALED_W'(count) * SCALED_W'(i_cfg.scale);

    always_comb begin
        nxt    = i_state;
        action = ACT_IGNORED;
        scaled = '0;
        case (i_item.cmd)
            CMD_START: begin
                nxt.coarse     = i_item.start_coarse[COARSE_W-1:0];
                nxt.fine       = i_item.start_fine[FINE_W-1:0];
                nxt.record_ok  = i_item.record_valid;
                nxt.dir        = DIR_NONE;
                nxt.changed    = 1'b0;
                nxt.run_active = 1'b1;
                action         = ACT_STARTED;
            end
            CMD_MEAS: begin
                if (i_state.run_active) begin
                    if (finish) begin
                        nxt.run_active = 1'b0;
                        if (i_state.changed || !i_state.record_ok) begin
                            action = ACT_WRITE;
                            scaled = product;
                        end else begin
                            action = ACT_KEEP;
                        end
                    end else begin
                        action      = ACT_APPLY;
                        nxt.changed = 1'b1;
                        if (below) begin
                            if (FINE_FLD_W'(fine_dn) <= i_cfg.fine_low) begin
                                nxt.coarse = i_state.coarse - crs_step;
                                nxt.fine   = recenter;
                                nxt.dir    = DIR_NONE;
                            end else begin
                                nxt.fine = fine_dn;
                                nxt.dir  = DIR_LOW;
                            end
                        end else begin
                            if (FINE_FLD_W'(fine_up) >= i_cfg.fine_high) begin
                                nxt.coarse = i_state.coarse + crs_step;
                                nxt.fine   = recenter;
                                nxt.dir    = DIR_NONE;
                            end else begin
                                nxt.fine = fine_up;
                                nxt.dir  = DIR_HIGH;
                            end
                        end
                    end
                end
            end
            CMD_ABORT: begin
                if (i_state.run_active) begin
                    nxt.run_active = 1'b0;
                    action         = ACT_ABORTED;
                end
            end
            default: begin
                action = ACT_IGNORED;
            end
        endcase
    end

    assign o_state              = nxt;
    assign o_result.action      = action;
    assign o_result.trim_word   = {16'(nxt.coarse), 16'(nxt.fine)};
    assign o_result.scaled_freq = scaled;

endmodule

`default_nettype wire
